// File: design/bcv_pkg.sv
// ---------------------------------------------------------------------------
// bcv_pkg
// Shared types, register indexes and the CRC-32C byte step for the
// per-block CRC-32C read verifier.
// ---------------------------------------------------------------------------
`default_nettype none

package bcv_pkg;

    // default parameter values
    localparam int unsigned SLOTS_DEF    = 4096;
    localparam int unsigned POS_BITS_DEF = 40;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_SIZE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRTY_LO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIRTY_HI   = 3'd4;

    localparam logic [24:0] BLOCK_SIZE_RST = 25'd4096;

    // item functions
    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_DATA = 1'b1;

    localparam logic [31:0] CRC32C_POLY = 32'h82F63B78;

    typedef struct packed {
        logic        func;
        logic [11:0] slot_index;
        logic [31:0] slot_crc;
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [39:0] buffer_offset;
        logic        last_byte;
    } t_in;

    typedef struct packed {
        logic        status;
        logic [39:0] bad_block;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_LOOK,
        ST_READ,
        ST_EXEC
    } t_state;

    // reflected CRC-32C over one byte, one bit per step
    function automatic logic [31:0] crc32c_byte(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

// File: design/bcv_ram.sv
// ---------------------------------------------------------------------------
// bcv_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module bcv_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: design/block_crc32c_verifier.sv
// ---------------------------------------------------------------------------
// block_crc32c_verifier
// Streams a read buffer byte by byte, computes CRC-32C per block and checks
// it against a table of stored slot values; reports once per buffer.
// ---------------------------------------------------------------------------
// After reset the slot table is swept to zero, one entry per cycle; during
// the sweep no item is taken (configuration writes still are).
// A slot load is written in idle. A data byte passes idle, a lookup and the
// byte step when it stays in the current block, and a slot table read too
// when it opens a new one; with block_size zero it goes from idle straight
// to the byte step. The first byte of a buffer, and the first byte after
// block_size is written or after a byte seen with block_size zero, first
// runs a bit-serial restoring divider to find the block number, after which
// block number and offset are tracked by increment. The result sits in its
// own register, so only a last byte waits, in its byte step, while an earlier report is still stalled.
`default_nettype none

module block_crc32c_verifier #(
    parameter int unsigned SLOTS    = bcv_pkg::SLOTS_DEF,
    parameter int unsigned POS_BITS = bcv_pkg::POS_BITS_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire bcv_pkg::t_in                i_in,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output bcv_pkg::t_out                    o_out,
    input  wire logic                        i_cfg_we,
    input  wire logic [bcv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bcv_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    import bcv_pkg::*;

    localparam int unsigned AW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int unsigned EW  = ((POS_BITS > 40) ? POS_BITS : 40) + 1;
    localparam int unsigned DCW = $clog2(POS_BITS + 1);
    localparam logic [AW-1:0]  LAST_ADDR = AW'(SLOTS - 1);
    localparam logic [20:0]    SLOTS_W   = 21'(SLOTS);
    localparam logic [DCW-1:0] DIV_LAST  = DCW'(POS_BITS - 1);

    // configuration registers
    logic [24:0] r_block_size;
    logic [39:0] r_file_size;
    logic [12:0] r_slot_count;
    logic [39:0] r_dirty_lo;
    logic [39:0] r_dirty_hi;

    // sequencer and datapath state
    t_state              r_state, n_state;
    logic [AW-1:0]       r_clr_addr;
    logic [POS_BITS-1:0] r_pos;
    logic [POS_BITS-1:0] r_q;
    logic [24:0]         r_rem;
    logic                r_div_ok;
    logic [DCW-1:0]      r_div_cnt;
    logic [POS_BITS-1:0] r_cur_blk;
    logic [EW-1:0]       r_blk_end;
    logic                r_elig;
    logic [31:0]         r_crc;
    logic [31:0]         r_slot_crc;
    logic                r_mis;
    logic [39:0]         r_bad;
    logic [7:0]          r_byte;
    logic                r_first;
    logic                r_last;
    logic                r_out_valid;
    t_out                r_out;

    // slot table ports
    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    logic [31:0]     ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [31:0]     ram_rdata;

    // input side
    logic            in_take;
    logic            load_ok;
    logic [63:0]     idx_ext;
    logic [63:0]     off_ext;

    // divider step
    logic [25:0]     div_trial;
    logic            div_bit;

    // block open
    logic [POS_BITS-1:0] blk_start;
    logic [EW-1:0]       end_raw;
    logic [EW-1:0]       end_cut;
    logic [EW-1:0]       blk_w;
    logic [20:0]         lim;
    logic                open_elig;

    // byte step
    logic [31:0]         crc_next;
    logic [EW-1:0]       pos_w;
    logic [POS_BITS-1:0] pos_inc;
    logic [63:0]         cur_ext;
    logic                exec_go;
    logic                blk_done;
    logic                blk_bad;

    assign in_take    = i_in_valid && (r_state == ST_IDLE);
    assign o_in_stall = (r_state != ST_IDLE);
    assign idx_ext    = 64'(i_in.slot_index);
    assign off_ext    = 64'(i_in.buffer_offset);
    assign load_ok    = (21'(i_in.slot_index) < SLOTS_W);
    assign cur_ext    = 64'(r_cur_blk);

    // slot table: sweep writes zero, loads write in idle
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = 32'd0;
        if (r_state == ST_CLEAR) begin
            ram_we = 1'b1;
        end else if (in_take && (i_in.func == FUNC_LOAD) && load_ok) begin
            ram_we    = 1'b1;
            ram_waddr = idx_ext[AW-1:0];
            ram_wdata = i_in.slot_crc;
        end
    end

    assign ram_raddr = r_q[AW-1:0];

    bcv_ram #(
        .WIDTH (32),
        .DEPTH (SLOTS),
        .AW    (AW)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // restoring divider step
    assign div_trial = {r_rem, r_q[POS_BITS-1]};
    assign div_bit   = (div_trial >= {1'b0, r_block_size});

    // block open terms
    assign blk_start = r_pos - POS_BITS'(r_rem);
    assign end_raw   = EW'(blk_start) + EW'(r_block_size);
    assign end_cut   = (end_raw > EW'(r_file_size)) ? EW'(r_file_size) : end_raw;
    assign blk_w     = EW'(r_q);
    assign lim       = (21'(r_slot_count) < SLOTS_W) ? 21'(r_slot_count) : SLOTS_W;
    assign open_elig = (r_rem == 25'd0) && (end_cut > EW'(blk_start))
                       && (blk_w < EW'(lim)) && (ram_rdata != 32'd0)
                       && !((blk_w >= EW'(r_dirty_lo)) && (blk_w < EW'(r_dirty_hi)));

    // byte step terms
    assign crc_next = crc32c_byte(r_crc, r_byte);
    assign pos_w    = EW'(r_pos);
    assign pos_inc  = r_pos + POS_BITS'(1);
    assign exec_go  = !(r_last && r_out_valid && i_out_stall);
    assign blk_done = (r_block_size != 25'd0) && r_elig && (pos_w < r_blk_end)
                      && (pos_w + EW'(1) == r_blk_end);
    assign blk_bad  = blk_done && ((crc_next ^ 32'hFFFFFFFF) != r_slot_crc);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == LAST_ADDR) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_take && (i_in.func == FUNC_DATA)) begin
                    if (r_block_size == 25'd0)                    n_state = ST_EXEC;
                    else if (i_in.first_byte || !r_div_ok)        n_state = ST_DIV;
                    else                                          n_state = ST_LOOK;
                end
            end
            ST_DIV: begin
                if (r_div_cnt == DIV_LAST) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                if (r_first || (r_q != r_cur_blk)) n_state = ST_READ;
                else                               n_state = ST_EXEC;
            end
            ST_READ: n_state = ST_EXEC;
            ST_EXEC: begin
                if (exec_go) n_state = ST_IDLE;
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_block_size <= BLOCK_SIZE_RST;
            r_file_size  <= '0;
            r_slot_count <= '0;
            r_dirty_lo   <= '0;
            r_dirty_hi   <= '0;
            r_pos        <= '0;
            r_q          <= '0;
            r_rem        <= '0;
            r_div_ok     <= 1'b1;
            r_div_cnt    <= '0;
            r_cur_blk    <= '0;
            r_blk_end    <= '0;
            r_elig       <= 1'b0;
            r_crc        <= '1;
            r_mis        <= 1'b0;
            r_bad        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;

            // result handoff: a new report replaces one taken this edge
            if ((r_state == ST_EXEC) && exec_go && r_last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // quotient is valid again after a full division
            if (i_cfg_we && (i_cfg_idx == REG_BLOCK_SIZE)) begin
                r_div_ok <= 1'b0;
            end else if ((r_state == ST_DIV) && (r_div_cnt == DIV_LAST)) begin
                r_div_ok <= 1'b1;
            end else if ((r_state == ST_EXEC) && exec_go && (r_block_size == 25'd0)) begin
                r_div_ok <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: r_clr_addr <= r_clr_addr + AW'(1);

                ST_IDLE: begin
                    if (in_take && (i_in.func == FUNC_DATA) && i_in.first_byte) begin
                        r_pos <= off_ext[POS_BITS-1:0];
                        r_mis <= 1'b0;
                        r_bad <= '0;
                    end
                    if (in_take && (i_in.func == FUNC_DATA)
                        && (i_in.first_byte || !r_div_ok)) begin
                        r_q       <= i_in.first_byte ? off_ext[POS_BITS-1:0] : r_pos;
                        r_rem     <= '0;
                        r_div_cnt <= '0;
                    end
                end

                ST_DIV: begin
                    r_rem     <= div_bit ? 25'(div_trial - {1'b0, r_block_size})
                                         : div_trial[24:0];
                    r_q       <= {r_q[POS_BITS-2:0], div_bit};
                    r_div_cnt <= r_div_cnt + DCW'(1);
                end

                ST_READ: begin
                    r_cur_blk <= r_q;
                    r_blk_end <= end_cut;
                    r_crc     <= '1;
                    r_elig    <= open_elig;
                end

                ST_EXEC: begin
                    if (exec_go) begin
                        if (r_block_size != 25'd0) begin
                            if (r_elig && (pos_w < r_blk_end)) r_crc <= crc_next;
                            // track quotient and remainder of the next position
                            if (pos_inc == '0) begin
                                r_q   <= '0;
                                r_rem <= '0;
                            end else if (r_rem + 25'd1 == r_block_size) begin
                                r_q   <= r_q + POS_BITS'(1);
                                r_rem <= '0;
                            end else begin
                                r_rem <= r_rem + 25'd1;
                            end
                        end
                        if ((r_block_size == 25'd0) || r_last || blk_done) r_elig <= 1'b0;
                        // first bad block of the buffer; cleared by the report
                        if (r_last) begin
                            r_mis <= 1'b0;
                            r_bad <= '0;
                        end else if (blk_bad && !r_mis) begin
                            r_mis <= 1'b1;
                            r_bad <= cur_ext[39:0];
                        end
                        r_pos <= pos_inc;
                    end
                end

                default: ;
            endcase

            // configuration writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BLOCK_SIZE: r_block_size <= i_cfg_wdata[24:0];
                    REG_FILE_SIZE:  r_file_size  <= i_cfg_wdata;
                    REG_SLOT_COUNT: r_slot_count <= i_cfg_wdata[12:0];
                    REG_DIRTY_LO:   r_dirty_lo   <= i_cfg_wdata;
                    REG_DIRTY_HI:   r_dirty_hi   <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_byte  <= i_in.data_byte;
            r_first <= i_in.first_byte;
            r_last  <= i_in.last_byte;
        end
        // keep the open block's slot value in step with loads
        if (in_take && (i_in.func == FUNC_LOAD) && load_ok && (idx_ext == cur_ext)) begin
            r_slot_crc <= i_in.slot_crc;
        end else if (r_state == ST_READ) begin
            r_slot_crc <= ram_rdata;
        end
        if ((r_state == ST_EXEC) && r_last && exec_go) begin
            r_out.status    <= r_mis || blk_bad;
            r_out.bad_block <= r_mis ? r_bad : (blk_bad ? cur_ext[39:0] : 40'd0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // a report only comes out of the byte step
    a_out_from_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_EXEC)
        else $error("report raised outside byte step");

    // a clean report carries no block number
    a_ok_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.status) |-> (o_out.bad_block == 40'd0))
        else $error("bad_block set with ok status");

    // divider never runs past its last step
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_div_cnt <= DIV_LAST))
        else $error("divider overran");

    // no item taken during table sweep
    a_clear_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> o_in_stall)
        else $error("input open during clear");

endmodule

`default_nettype wire

// File: tb/crc_block_checker.sv
// ---------------------------------------------------------------------------
// crc_block_checker
// Watches the item, report and register ports of the CRC-32C block
// verifier, predicts each buffer report from a model of its own and compares
// every report field by field.
// ---------------------------------------------------------------------------
`default_nettype none

module crc_block_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_stall,
    input  wire bcv_pkg::t_in                   i_in,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_stall,
    input  wire bcv_pkg::t_out                  i_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [bcv_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [bcv_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bcv_pkg::*;

    localparam logic [63:0] POS_MASK = (64'd1 << 40) - 64'd1;

    // predicted register copy
    logic [63:0] blk_bytes, file_len, slots_used, skip_lo, skip_hi;

    // predicted block state
    logic [31:0] slot_crcs [4096];
    logic [31:0] crc_acc;
    logic [63:0] pos, cur_blk, blk_end, first_bad;
    logic        checking, bad_seen;

    t_out expected_reports [$];
    int   fail_count;

    assign o_fail_count = fail_count;

    function automatic logic [31:0] crc32c_step(input logic [31:0] c_in, input logic [7:0] b);
        logic [31:0] c;
        c = c_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) c = (c >> 1) ^ 32'h82F63B78;
            else c = c >> 1;
        end
        return c;
    endfunction

    // one accepted item: update state, queue a report on a last byte
    task automatic predict_item(input t_in it);
        logic [63:0] blk, start, stop, lim;
        t_out        rep;
        if (it.func == FUNC_LOAD) begin
            slot_crcs[it.slot_index] = it.slot_crc;
            return;
        end
        if (it.first_byte) begin
            pos       = {24'd0, it.buffer_offset};
            bad_seen  = 1'b0;
            first_bad = 64'd0;
        end
        if (blk_bytes == 64'd0) begin
            checking = 1'b0;
        end else begin
            blk = pos / blk_bytes;
            if (it.first_byte || blk != cur_blk) begin
                start = blk * blk_bytes;
                stop  = start + blk_bytes;
                if (stop > file_len) stop = file_len;
                lim     = (slots_used < 64'd4096) ? slots_used : 64'd4096;
                cur_blk = blk & POS_MASK;
                blk_end = stop;
                crc_acc = 32'hFFFFFFFF;
                checking = (start == pos) && (stop > start) && (blk < lim) &&
                           !(blk >= skip_lo && blk < skip_hi);
                if (checking) checking = slot_crcs[blk[11:0]] != 32'd0;
            end
            if (checking && pos < blk_end) begin
                crc_acc = crc32c_step(crc_acc, it.data_byte);
                if (pos + 64'd1 == blk_end) begin
                    if (~crc_acc != slot_crcs[cur_blk[11:0]] && !bad_seen) begin
                        bad_seen  = 1'b1;
                        first_bad = cur_blk;
                    end
                    checking = 1'b0;
                end
            end
        end
        pos = (pos + 64'd1) & POS_MASK;
        if (it.last_byte) begin
            rep.status    = bad_seen;
            rep.bad_block = bad_seen ? first_bad[39:0] : 40'd0;
            expected_reports.push_back(rep);
            bad_seen  = 1'b0;
            first_bad = 64'd0;
            checking  = 1'b0;
        end
    endtask

    initial begin
        fail_count = 0;
        o_pending  = 0;
    end

    always @(posedge i_clk) begin
        t_out exp_rep;
        if (!i_rst_n) begin
            blk_bytes  = 64'd4096;
            file_len   = 64'd0;
            slots_used = 64'd0;
            skip_lo    = 64'd0;
            skip_hi    = 64'd0;
            foreach (slot_crcs[k]) slot_crcs[k] = 32'd0;
            crc_acc   = 32'hFFFFFFFF;
            pos       = 64'd0;
            cur_blk   = 64'd0;
            blk_end   = 64'd0;
            first_bad = 64'd0;
            checking  = 1'b0;
            bad_seen  = 1'b0;
        end else begin
            // register writes
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_BLOCK_SIZE: blk_bytes  = {39'd0, i_cfg_wdata[24:0]};
                    REG_FILE_SIZE:  file_len   = {24'd0, i_cfg_wdata};
                    REG_SLOT_COUNT: slots_used = {51'd0, i_cfg_wdata[12:0]};
                    REG_DIRTY_LO:   skip_lo    = {24'd0, i_cfg_wdata};
                    REG_DIRTY_HI:   skip_hi    = {24'd0, i_cfg_wdata};
                    default: ;
                endcase
            end
            // item transfer
            if (i_in_valid && !i_in_stall) predict_item(i_in);
            // report transfer
            if (i_out_valid && !i_out_stall) begin
                if (expected_reports.size() == 0) begin
                    $error("unexpected report: status %0d bad_block %0d",
                           i_out.status, i_out.bad_block);
                    fail_count++;
                end else begin
                    exp_rep = expected_reports.pop_front();
                    if (i_out.status !== exp_rep.status) begin
                        $error("status: expected %0d actual %0d",
                               exp_rep.status, i_out.status);
                        fail_count++;
                    end
                    if (i_out.bad_block !== exp_rep.bad_block) begin
                        $error("bad_block: expected %0d actual %0d",
                               exp_rep.bad_block, i_out.bad_block);
                        fail_count++;
                    end
                end
            end
        end
        o_pending = expected_reports.size();
    end

endmodule

`default_nettype wire

// File: tb/tb_block_crc32c_verifier.sv
// ---------------------------------------------------------------------------
// tb_block_crc32c_verifier
// Drives slot loads and read buffers into the CRC-32C block verifier under
// several register settings and idle patterns; a side checker predicts and
// compares every buffer report.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_block_crc32c_verifier;
    timeunit 1ns;
    timeprecision 1ps;
    import bcv_pkg::*;

    localparam longint unsigned MAX40 = (64'd1 << 40) - 1;
    localparam int TARGET_ITEMS = 1550;
    localparam int SETTLE_CYCLES = 60;
    localparam int IN_W = $bits(t_in);

    logic                  i_clk, i_rst_n;
    logic                  i_in_valid, o_in_stall;
    t_in                   i_in;
    logic                  o_out_valid, i_out_stall;
    t_out                  o_out;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    int                    fail_count, pending;

    // current idle rates, percent per cycle
    int tx_idle, rx_idle;
    int n_items;

    // register mirror used to build matching slot values
    longint unsigned bsz, fsz;

    block_crc32c_verifier DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in(i_in),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    crc_block_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in(i_in),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out(o_out),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // run limit
    initial begin
        #5ms;
        $display("*** FAILED ***");
        $finish;
    end

    // random report stall
    always @(negedge i_clk) begin
        i_out_stall <= (rx_idle != 0) && ($urandom_range(99) < rx_idle);
    end

    function automatic logic [31:0] block_crc(input logic [7:0] bytes[$], input int s,
                                              input int e);
        logic [31:0] c;
        c = 32'hFFFFFFFF;
        for (int i = s; i < e; i++) begin
            c ^= {24'd0, bytes[i]};
            for (int k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC32C_POLY) : (c >> 1);
        end
        return ~c;
    endfunction

    // random filler for every item field
    function automatic t_in rand_item();
        logic [95:0] r;
        r = {$urandom, $urandom, $urandom};
        return t_in'(r[IN_W-1:0]);
    endfunction

    // one transfer on the item channel, with random idle cycles first
    task automatic send(input t_in it);
        while (tx_idle != 0 && $urandom_range(99) < tx_idle) begin
            i_in_valid <= 1'b0;
            i_in       <= rand_item();
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        #0.5;
        while (o_in_stall) begin
            @(negedge i_clk);
            #0.5;
        end
        @(negedge i_clk);
        n_items++;
    endtask

    task automatic stop_sending();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic load_slot(input logic [11:0] idx, input logic [31:0] val);
        t_in it;
        it            = rand_item();
        it.func       = FUNC_LOAD;
        it.slot_index = idx;
        it.slot_crc   = val;
        send(it);
    endtask

    // wait until every report has come and the block has settled
    task automatic drain();
        stop_sending();
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val[39:0];
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        if (idx == REG_BLOCK_SIZE) bsz = val & 64'h1FFFFFF;
        if (idx == REG_FILE_SIZE) fsz = val & MAX40;
    endtask

    task automatic set_regs(input longint unsigned b, input longint unsigned f,
                            input longint unsigned sc, input longint unsigned lo,
                            input longint unsigned hi);
        drain();
        write_reg(REG_BLOCK_SIZE, b);
        write_reg(REG_FILE_SIZE, f);
        write_reg(REG_SLOT_COUNT, sc);
        write_reg(REG_DIRTY_LO, lo);
        write_reg(REG_DIRTY_HI, hi);
        @(negedge i_clk);
    endtask

    // slot loads for the covered blocks, then the buffer itself
    task automatic run_buffer(input longint unsigned off, input int len,
                              input bit with_first, input int good_pct);
        logic [7:0]      bytes[$];
        longint unsigned b0, b1, s, e;
        logic [31:0]     val;
        int              r;
        t_in             it;
        for (int i = 0; i < len; i++) bytes.push_back(8'($urandom));
        if (bsz != 0 && off + len <= MAX40) begin
            b0 = off / bsz;
            b1 = (off + len - 1) / bsz;
            for (longint unsigned b = b0; b <= b1 && b < 4096 && b < b0 + 8; b++) begin
                s = b * bsz;
                e = s + bsz;
                if (e > fsz) e = fsz;
                r = $urandom_range(99);
                if (r < good_pct && s >= off && e <= off + len && e > s)
                    val = block_crc(bytes, int'(s - off), int'(e - off));
                else if (r < good_pct + 15) val = 32'd0;
                else val = $urandom;
                load_slot(b[11:0], val);
            end
        end
        for (int i = 0; i < len; i++) begin
            it               = rand_item();
            it.func          = FUNC_DATA;
            it.data_byte     = bytes[i];
            it.first_byte    = with_first && i == 0;
            if (it.first_byte) it.buffer_offset = off[39:0];
            it.last_byte     = i == len - 1;
            send(it);
        end
    endtask

    task automatic random_regs();
        longint unsigned b, f, sc, lo;
        case ($urandom_range(9))
            0:       b = 64'd0;
            1:       b = 64'($urandom_range(17, 64));
            default: b = 64'($urandom_range(1, 16));
        endcase
        f  = ($urandom_range(5) == 0) ? MAX40 : longint'($urandom_range(0, 130)) * (b + 1);
        sc = ($urandom_range(3) == 0) ? 64'($urandom_range(0, 8191)) : 64'd4096;
        lo = 64'($urandom_range(0, 130));
        set_regs(b, f, sc, lo, lo + 64'($urandom_range(0, 20)));
    endtask

    task automatic random_buffer();
        longint unsigned off;
        int len, unit;
        unit = (bsz == 0) ? 4 : int'(bsz);
        off  = longint'($urandom_range(0, 130)) * unit;
        case ($urandom_range(9))
            0: off = {$urandom, $urandom} & MAX40;
            1: off = off + $urandom_range(0, unit);
            default: ;
        endcase
        if ($urandom_range(1)) len = unit * $urandom_range(1, 4);
        else len = $urandom_range(1, 4 * unit);
        if (len > 64) len = $urandom_range(1, 64);
        run_buffer(off, len, $urandom_range(19) != 0, 75);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_stall = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_BLOCK_SIZE;
        i_cfg_wdata = '0;
        tx_idle     = 0;
        rx_idle     = 0;
        n_items     = 0;
        bsz         = 4096;
        fsz         = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset settings check nothing
        load_slot(12'd4095, 32'hFFFFFFFF);
        load_slot(12'd0, 32'd0);
        run_buffer(0, 3, 1, 100);
        // short last block cut at file end, one bad block likely
        set_regs(4, 10, 8191, 0, 0);
        run_buffer(0, 10, 1, 60);
        // buffer ending inside a block, then continuing without a first byte
        run_buffer(2, 5, 1, 100);
        run_buffer(0, 3, 0, 100);
        // everything in the dirty range
        set_regs(2, MAX40, 4096, 0, MAX40);
        run_buffer(0, 4, 1, 100);
        // zero block size
        set_regs(0, MAX40, 4096, 0, 0);
        run_buffer(5, 2, 1, 100);
        // position wrap at the top offset
        set_regs(1, MAX40, 0, MAX40, MAX40);
        run_buffer(MAX40, 2, 1, 100);
        // widest block size, slot count zero
        set_regs(64'h1FFFFFF, 0, 0, 0, 0);
        run_buffer(64'h1FFFFFE, 2, 1, 100);

        // random: three idle patterns
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle = (ph == 0) ? 10 : (ph == 1) ? 68 : 0;
            rx_idle = (ph == 0) ? 68 : (ph == 1) ? 10 : 0;
            random_regs();
            for (int n = n_items; n_items < n + TARGET_ITEMS / 3; ) begin
                if ($urandom_range(15) == 0) random_regs();
                if ($urandom_range(9) == 0) load_slot(12'($urandom), $urandom);
                else random_buffer();
                // sender holds off until all reports are in
                if (ph == 1 && n_items > n + 100 && n_items < n + 140) begin
                    stop_sending();
                    while (pending != 0) @(negedge i_clk);
                end
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
design/bcv_pkg.sv
design/bcv_ram.sv
design/block_crc32c_verifier.sv
tb/crc_block_checker.sv
tb/tb_block_crc32c_verifier.sv
